### rtl/npd_pkg.sv
// ----------------------------------------------------------------------------
// npd_pkg
// Shared types and constants for the nearest point direction block.
// ----------------------------------------------------------------------------
package npd_pkg;

  // operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam int CoordW   = 16;
  localparam int IdW      = 16;
  localparam int SqW      = 32;   // one squared axis difference
  localparam int DistW    = 33;   // sum of two squares
  localparam int AccW     = 64;   // unit magnitude search accumulators
  localparam int MagW     = 15;   // magnitude 0..16384
  localparam int BitIdxW  = 4;
  localparam logic [BitIdxW-1:0] MagTopBit = 4'd14;

  // controller to datapath
  typedef struct packed {
    logic idle;       // request may be taken
    logic exec;       // run clear / add, arm a query
    logic scan_mul;   // square differences of the fetched entry
    logic scan_cmp;   // compare and step the index
    logic dir_init;   // arm the magnitude search for x
    logic dir_a;      // form candidate accumulators
    logic dir_b;      // test candidate, step the bit
    logic emit;       // load the output register
  } npd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_fire;
    logic is_query;
    logic count_zero;
    logic scan_last;
    logic best_zero;
    logic bit_last;
    logic comp_last;
    logic out_free;
  } npd_stat_t;

endpackage

### rtl/npd_if.sv
// ----------------------------------------------------------------------------
// npd_in_if / npd_out_if
// Request and result channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface npd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [15:0]        point_id;

  modport source(output valid, operation, pos_x, pos_y, point_id, input ready);
  modport sink(input valid, operation, pos_x, pos_y, point_id, output ready);
endinterface

interface npd_out_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic [15:0]        nearest_id;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic               table_full;

  modport source(output valid, found, nearest_id, dir_x, dir_y, table_full,
                 input ready);
  modport sink(input valid, found, nearest_id, dir_x, dir_y, table_full,
               output ready);
endinterface

### rtl/npd_ctrl.sv
// ----------------------------------------------------------------------------
// npd_ctrl
// Sequencer: request intake, table scan, magnitude search, result hand-off.
// ----------------------------------------------------------------------------
module npd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  npd_pkg::npd_stat_t stat,
  output npd_pkg::npd_cmd_t  cmd
);
  import npd_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_EXEC     = 8'b0000_0010,
    S_SCAN_RD  = 8'b0000_0100,
    S_SCAN_MUL = 8'b0000_1000,
    S_SCAN_CMP = 8'b0001_0000,
    S_DIR_INIT = 8'b0010_0000,
    S_DIR_A    = 8'b0100_0000,
    S_DIR_B    = 8'b1000_0000
  } state_t;

  // emit flag: the finished result waits here for the output register
  logic   emit_r, emit_nxt;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    emit_nxt  = emit_r;
    cmd       = '0;
    if (emit_r) begin
      // result waits for the output register
      cmd.emit = stat.out_free;
      if (stat.out_free) begin
        emit_nxt  = 1'b0;
        state_nxt = S_IDLE;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          cmd.idle = 1'b1;
          if (stat.in_fire) state_nxt = S_EXEC;
        end
        S_EXEC: begin
          cmd.exec = 1'b1;
          if (stat.is_query && !stat.count_zero) state_nxt = S_SCAN_RD;
          else emit_nxt = 1'b1;
        end
        S_SCAN_RD:  state_nxt = S_SCAN_MUL;
        S_SCAN_MUL: begin
          cmd.scan_mul = 1'b1;
          state_nxt    = S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          cmd.scan_cmp = 1'b1;
          state_nxt    = stat.scan_last ? S_DIR_INIT : S_SCAN_RD;
        end
        S_DIR_INIT: begin
          cmd.dir_init = 1'b1;
          if (stat.best_zero) emit_nxt = 1'b1;
          else state_nxt = S_DIR_A;
        end
        S_DIR_A: begin
          cmd.dir_a = 1'b1;
          state_nxt = S_DIR_B;
        end
        S_DIR_B: begin
          cmd.dir_b = 1'b1;
          if (stat.bit_last && stat.comp_last) emit_nxt = 1'b1;
          else state_nxt = S_DIR_A;
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

endmodule

### rtl/npd_dp.sv
// ----------------------------------------------------------------------------
// npd_dp
// Point table, distance scan, bitwise unit-magnitude search, output register.
// ----------------------------------------------------------------------------
module npd_dp #(
  parameter int MAX_TARGETS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  npd_in_if.sink             in_ch,
  npd_out_if.source          out_ch,
  input  npd_pkg::npd_cmd_t  cmd,
  output npd_pkg::npd_stat_t stat
);
  import npd_pkg::*;

  localparam int CW = $clog2(MAX_TARGETS + 1);
  localparam int AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int EW = 2 * CoordW + IdW;

  // table
  logic [EW-1:0] mem [MAX_TARGETS];
  logic [EW-1:0] rd_q;
  logic [CW-1:0] count_r;
  logic [AW-1:0] idx_r;

  // latched request
  logic [1:0]              op_r;
  logic signed [CoordW-1:0] px_r, py_r, ax_r, ay_r;
  logic [IdW-1:0]          aid_r;

  // scan
  logic [SqW-1:0]   sx_r, sy_r;
  logic             xneg_r, yneg_r;
  logic [IdW-1:0]   id_r;
  logic             have_r;
  logic [DistW-1:0] best_r;
  logic [SqW-1:0]   bsx_r, bsy_r;
  logic             bxneg_r, byneg_r;
  logic [IdW-1:0]   bid_r;

  // magnitude search
  logic [AccW-1:0]    s_r, l_r, sc_r, lc_r;
  logic [MagW-1:0]    m_r;
  logic [BitIdxW-1:0] k_r;
  logic               comp_r;

  // result
  logic             res_found_r, res_full_r;
  logic [IdW-1:0]   res_id_r;
  logic [15:0]      res_dx_r, res_dy_r;
  logic             ov_r;

  logic in_fire;
  assign in_ch.ready = cmd.idle;
  assign in_fire     = in_ch.valid && cmd.idle;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_ch.operation;
      ax_r  <= in_ch.pos_x;
      ay_r  <= in_ch.pos_y;
      aid_r <= in_ch.point_id;
      px_r  <= in_ch.pos_x;
      py_r  <= in_ch.pos_y;
    end
  end

  logic add_ok;
  assign add_ok = (op_r == OP_ADD) && (count_r < CW'(MAX_TARGETS));

  always_ff @(posedge clk) begin
    if (cmd.exec && add_ok) mem[count_r[AW-1:0]] <= {ax_r, ay_r, aid_r};
    rd_q <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      if (op_r == OP_CLEAR) count_r <= '0;
      else if (add_ok) count_r <= count_r + CW'(1);
    end
  end

  // difference squares
  logic signed [CoordW:0]     dx, dy;
  logic signed [2*CoordW+1:0] px2, py2;
  assign dx  = $signed({rd_q[EW-1], rd_q[EW-1 -: CoordW]}) - $signed({px_r[CoordW-1], px_r});
  assign dy  = $signed({rd_q[IdW+CoordW-1], rd_q[IdW +: CoordW]})
             - $signed({py_r[CoordW-1], py_r});
  assign px2 = dx * dx;
  assign py2 = dy * dy;

  logic [DistW-1:0] d2;
  assign d2 = {1'b0, sx_r} + {1'b0, sy_r};

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      idx_r  <= '0;
      have_r <= 1'b0;
    end
    if (cmd.scan_mul) begin
      sx_r   <= px2[SqW-1:0];
      sy_r   <= py2[SqW-1:0];
      xneg_r <= dx[CoordW];
      yneg_r <= dy[CoordW];
      id_r   <= rd_q[IdW-1:0];
    end
    if (cmd.scan_cmp) begin
      idx_r <= idx_r + AW'(1);
      if (!have_r || d2 <= best_r) begin
        have_r  <= 1'b1;
        best_r  <= d2;
        bsx_r   <= sx_r;
        bsy_r   <= sy_r;
        bxneg_r <= xneg_r;
        byneg_r <= yneg_r;
        bid_r   <= id_r;
      end
    end
  end

  // greedy bit search: largest m with (2m-1)^2 * d2 <= dsq << 30,
  // tracking S = m^2*d2 and L = m*d2 with shifts and adds only
  logic [AccW-1:0] dd, rhs, tsq;
  logic [SqW-1:0]  dsq;
  logic            dneg, take;
  logic [MagW-1:0] m_new;
  logic [15:0]     signed_m;
  assign dd       = AccW'(best_r);
  assign dsq      = comp_r ? bsy_r : bsx_r;
  assign dneg     = comp_r ? byneg_r : bxneg_r;
  assign rhs      = {2'b0, dsq, 30'b0};
  assign tsq      = (sc_r << 2) - (lc_r << 2) + dd;
  assign take     = !m_r[MagW-1] && (tsq <= rhs);
  assign m_new    = take ? (m_r | (MagW'(1) << k_r)) : m_r;
  assign signed_m = dneg ? (16'd0 - {1'b0, m_new}) : {1'b0, m_new};

  always_ff @(posedge clk) begin
    if (cmd.dir_init || (cmd.dir_b && k_r == '0)) begin
      s_r <= '0;
      l_r <= '0;
      m_r <= '0;
      k_r <= MagTopBit;
    end
    if (cmd.dir_init) comp_r <= 1'b0;
    if (cmd.dir_a) begin
      sc_r <= s_r + (l_r << (k_r + BitIdxW'(1))) + (dd << {k_r, 1'b0});
      lc_r <= l_r + (dd << k_r);
    end
    if (cmd.dir_b) begin
      if (k_r != '0) begin
        k_r <= k_r - BitIdxW'(1);
        m_r <= m_new;
        if (take) begin
          s_r <= sc_r;
          l_r <= lc_r;
        end
      end else begin
        comp_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_found_r <= 1'b0;
      res_id_r    <= '0;
      res_dx_r    <= '0;
      res_dy_r    <= '0;
      res_full_r  <= (op_r == OP_ADD) && !add_ok;
    end
    if (cmd.dir_init) begin
      res_found_r <= 1'b1;
      res_id_r    <= bid_r;
    end
    if (cmd.dir_b && k_r == '0) begin
      if (comp_r) res_dy_r <= signed_m;
      else res_dx_r <= signed_m;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ch.found      <= res_found_r;
      out_ch.nearest_id <= res_id_r;
      out_ch.dir_x      <= res_dx_r;
      out_ch.dir_y      <= res_dy_r;
      out_ch.table_full <= res_full_r;
    end
  end

  assign out_ch.valid = ov_r;

  assign stat.in_fire    = in_fire;
  assign stat.is_query   = (op_r == OP_QUERY);
  assign stat.count_zero = (count_r == '0);
  assign stat.scan_last  = (CW'(idx_r) == count_r - CW'(1));
  assign stat.best_zero  = (best_r == '0);
  assign stat.bit_last   = (k_r == '0);
  assign stat.comp_last  = comp_r;
  assign stat.out_free   = !ov_r || out_ch.ready;

endmodule

### rtl/nearest_point_direction.sv
// ----------------------------------------------------------------------------
// nearest_point_direction
// Point table with nearest-point search and Q1.14 unit direction output.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  in_ch   | in  | valid/ready | operation, pos_x, pos_y, point_id
//  out_ch  | out | valid/ready | found, nearest_id, dir_x, dir_y, table_full
//
//  Clear, add and unused codes skip the scan. A query scans the N stored
//  points one entry at a time through one table read port, picks the
//  nearest point, then runs the two magnitude searches (15 bits each)
//  when the nearest distance is nonzero.
//  Reset (rst_n low, synchronous) empties the table; stored entries keep
//  their contents, only entries below the count are ever read.
//  A result waiting on out_ch holds the sequencer only at its final step.
// ----------------------------------------------------------------------------
module nearest_point_direction #(
  parameter int MAX_TARGETS = 64
) (
  input logic        clk,
  input logic        rst_n,
  npd_in_if.sink     in_ch,
  npd_out_if.source  out_ch
);
  import npd_pkg::*;

  npd_cmd_t  cmd;
  npd_stat_t stat;

  npd_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .cmd  (cmd)
  );

  npd_dp #(.MAX_TARGETS(MAX_TARGETS)) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cmd   (cmd),
    .stat  (stat)
  );

endmodule

### rtl/npd_checker.sv
// ----------------------------------------------------------------------------
// npd_checker
// Port-level checks on the result channel.
// ----------------------------------------------------------------------------
module npd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        found,
  input logic [15:0] nearest_id,
  input logic [15:0] dir_x,
  input logic [15:0] dir_y,
  input logic        table_full
);

  // stalled result keeps its nearest_id and dir_x
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(nearest_id) && $stable(dir_x))
    else $error("stalled result changed");

  // nothing found means empty fields
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> nearest_id == 16'd0 && dir_x == 16'd0 && dir_y == 16'd0)
    else $error("fields set without a found point");

  // dropped add is never a query
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && table_full |-> !found)
    else $error("full flag on a query");

  // unit vector components stay within one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(dir_x) <= 16'sd16384 && $signed(dir_x) >= -16'sd16384 &&
                   $signed(dir_y) <= 16'sd16384 && $signed(dir_y) >= -16'sd16384))
    else $error("direction out of range");

endmodule

bind nearest_point_direction npd_checker u_npd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .found     (out_ch.found),
  .nearest_id(out_ch.nearest_id),
  .dir_x     (out_ch.dir_x),
  .dir_y     (out_ch.dir_y),
  .table_full(out_ch.table_full)
);
